>>> rtl/trf_pkg.sv
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants for the tilt reminder controller
// Holds the payload structs, the state and reason codes and the register map.
// ----------------------------------------------------------------------------
package trf_pkg;

    localparam int SNOOZE_PRESSES_DEF = 4;

    localparam logic [15:0] SNOOZE_SECONDS_RST        = 16'd300;
    localparam logic [15:0] TILT_INTERVAL_SECONDS_RST = 16'd900;
    localparam logic [15:0] TILT_MIN_SECONDS_RST      = 16'd60;

    localparam logic [2:0]  PRESS_MAX = 3'd7;

    typedef enum logic [3:0] {
        ST_INIT           = 4'd0,
        ST_WAIT           = 4'd1,
        ST_TRAVEL         = 4'd2,
        ST_TRAVEL_ELAPSED = 4'd3,
        ST_TILT_STARTED   = 4'd4,
        ST_WAITING_TILT   = 4'd5,
        ST_SNOOZED        = 4'd6,
        ST_IN_TILT        = 4'd7,
        ST_DURATION_OK    = 4'd8,
        ST_STOPPED        = 4'd9
    } state_t;

    typedef enum logic [3:0] {
        RS_OTHER           = 4'd0,
        RS_DISABLED        = 4'd1,
        RS_SNOOZED         = 4'd2,
        RS_NOT_SEATED      = 4'd3,
        RS_TILT_BEGIN      = 4'd4,
        RS_TILT_REQUESTED  = 4'd5,
        RS_INITIAL_REQUEST = 4'd6,
        RS_END             = 4'd7,
        RS_END_OK          = 4'd8,
        RS_COMPLETE        = 4'd9
    } reason_t;

    typedef enum logic [1:0] {
        CFG_SNOOZE_SECONDS        = 2'd0,
        CFG_TILT_INTERVAL_SECONDS = 2'd1,
        CFG_TILT_MIN_SECONDS      = 2'd2,
        CFG_UNUSED                = 2'd3
    } cfg_index_t;

    localparam logic [1:0] SEAT_SEATED     = 2'd1;
    localparam logic [1:0] SEAT_CONFIRMING = 2'd2;

    localparam logic [2:0] ANGLE_BEGUN      = 3'd1;
    localparam logic [2:0] ANGLE_IN_TILT    = 3'd2;
    localparam logic [2:0] ANGLE_CONFIRMING = 3'd3;
    localparam logic [2:0] ANGLE_ENDED      = 3'd4;

    typedef struct packed {
        logic [31:0] time_seconds;
        logic        button_pressed;
        logic        enabled;
        logic [1:0]  seating_code;
        logic [2:0]  angle_code;
        logic        moving;
    } in_item_t;

    typedef struct packed {
        logic [3:0] notify_state;
        logic [3:0] reason_code;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } cfg_req_t;

    // Control between pipeline stages
    typedef struct packed {
        logic item_valid;
        logic advance;
    } stage_ctl_t;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

>>> rtl/trf_stream_if.sv
// ----------------------------------------------------------------------------
// trf_stream_if: valid/ready channel
// Carries one request per accepting edge; payload type set per instance.
// ----------------------------------------------------------------------------
interface trf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

>>> rtl/trf_in_stage.sv
// ----------------------------------------------------------------------------
// trf_in_stage: input register
// Captures one input request and holds it until the core consumes it.
// ----------------------------------------------------------------------------
module trf_in_stage
    import trf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    input  logic       advance,
    output stage_ctl_t ctl,
    output in_item_t   item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    assign ctl.item_valid = valid_reg;
    assign ctl.advance    = advance;
    assign item           = item_reg;

endmodule

>>> rtl/trf_core.sv
// ----------------------------------------------------------------------------
// trf_core: reminder state machine
// Holds the configuration and controller state and steps once per request.
// ----------------------------------------------------------------------------
module trf_core
    import trf_pkg::*;
#(
    parameter int SNOOZE_PRESSES = SNOOZE_PRESSES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_req_t   cfg_data,
    input  stage_ctl_t ctl,
    input  in_item_t   item,
    output out_item_t  result
);

    localparam logic [2:0] PRESS_LIMIT = 3'(SNOOZE_PRESSES);

    logic [15:0] snooze_seconds_reg;
    logic [15:0] tilt_interval_seconds_reg;
    logic [15:0] tilt_min_seconds_reg;

    state_t      mode_reg,         mode_next;
    reason_t     reason_reg,       reason_next;
    logic [15:0] second_count_reg, second_count_next;
    logic [2:0]  press_count_reg,  press_count_next;
    logic [31:0] last_time_reg;

    logic seated;
    logic tick;
    logic held_tilt;

    assign cfg_ready = 1'b1;

    assign seated    = (item.seating_code == SEAT_SEATED) ||
                       (item.seating_code == SEAT_CONFIRMING);
    assign tick      = (item.time_seconds != last_time_reg);
    assign held_tilt = (item.angle_code == ANGLE_IN_TILT) ||
                       (item.angle_code == ANGLE_CONFIRMING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snooze_seconds_reg        <= SNOOZE_SECONDS_RST;
            tilt_interval_seconds_reg <= TILT_INTERVAL_SECONDS_RST;
            tilt_min_seconds_reg      <= TILT_MIN_SECONDS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_data.index))
                CFG_SNOOZE_SECONDS:        snooze_seconds_reg        <= cfg_data.data;
                CFG_TILT_INTERVAL_SECONDS: tilt_interval_seconds_reg <= cfg_data.data;
                CFG_TILT_MIN_SECONDS:      tilt_min_seconds_reg      <= cfg_data.data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= ST_INIT;
            reason_reg       <= RS_OTHER;
            second_count_reg <= 16'd0;
            press_count_reg  <= 3'd0;
            last_time_reg    <= 32'd0;
        end
        else if (ctl.advance)
        begin
            mode_reg         <= mode_next;
            reason_reg       <= reason_next;
            second_count_reg <= second_count_next;
            press_count_reg  <= press_count_next;
            last_time_reg    <= item.time_seconds;
        end
    end

    always_comb
    begin
        mode_next         = mode_reg;
        reason_next       = reason_reg;
        second_count_next = second_count_reg;
        press_count_next  = press_count_reg;

        unique case (mode_reg)
            ST_INIT:
            begin
                reason_next       = RS_OTHER;
                press_count_next  = 3'd0;
                second_count_next = 16'd0;
                if (item.seating_code == SEAT_SEATED)
                begin
                    mode_next = ST_WAIT;
                end
                if (!item.enabled)
                begin
                    mode_next = ST_INIT;
                end
            end
            ST_TRAVEL_ELAPSED:
            begin
                mode_next = item.moving ? ST_TRAVEL_ELAPSED : ST_WAITING_TILT;
            end
            ST_WAIT:
            begin
                reason_next = RS_OTHER;
                if (item.moving)
                begin
                    mode_next = ST_TRAVEL;
                end
                if (seated)
                begin
                    if (tick)
                    begin
                        second_count_next = sat_inc16(second_count_reg);
                        if (second_count_next >= tilt_interval_seconds_reg ||
                            item.angle_code == ANGLE_IN_TILT)
                        begin
                            mode_next = ST_TILT_STARTED;
                        end
                    end
                end
                else
                begin
                    mode_next = ST_INIT;
                end
                if (!item.enabled)
                begin
                    mode_next   = ST_INIT;
                    reason_next = RS_DISABLED;
                end
            end
            ST_TRAVEL:
            begin
                reason_next = RS_OTHER;
                mode_next   = item.moving ? ST_TRAVEL : ST_WAIT;
                if (tick)
                begin
                    second_count_next = sat_inc16(second_count_reg);
                end
                if (!seated)
                begin
                    mode_next = ST_INIT;
                end
                if (!item.enabled)
                begin
                    mode_next   = ST_INIT;
                    reason_next = RS_DISABLED;
                end
            end
            ST_WAITING_TILT:
            begin
                reason_next       = RS_OTHER;
                second_count_next = 16'd0;
                if (item.button_pressed)
                begin
                    if (press_count_reg < PRESS_MAX)
                    begin
                        press_count_next = press_count_reg + 3'd1;
                    end
                    if (press_count_next >= PRESS_LIMIT)
                    begin
                        mode_next   = ST_SNOOZED;
                        reason_next = RS_SNOOZED;
                    end
                end
                else
                begin
                    press_count_next = 3'd0;
                end
                // travel wins and keeps any snooze reason
                priority if (item.moving)
                begin
                    mode_next = ST_TRAVEL_ELAPSED;
                end
                else if (!seated)
                begin
                    mode_next   = ST_STOPPED;
                    reason_next = RS_NOT_SEATED;
                end
                else
                begin
                    if (item.angle_code == ANGLE_BEGUN ||
                        item.angle_code == ANGLE_IN_TILT)
                    begin
                        mode_next   = ST_IN_TILT;
                        reason_next = RS_TILT_BEGIN;
                    end
                    if (!item.enabled)
                    begin
                        mode_next   = ST_INIT;
                        reason_next = RS_DISABLED;
                    end
                end
            end
            ST_SNOOZED:
            begin
                reason_next = RS_OTHER;
                if (tick)
                begin
                    second_count_next = sat_inc16(second_count_reg);
                    if (second_count_next >= snooze_seconds_reg ||
                        item.angle_code == ANGLE_IN_TILT)
                    begin
                        mode_next   = ST_WAITING_TILT;
                        reason_next = RS_TILT_REQUESTED;
                    end
                end
                if (!seated)
                begin
                    mode_next   = ST_STOPPED;
                    reason_next = RS_NOT_SEATED;
                end
                if (!item.enabled)
                begin
                    mode_next   = ST_INIT;
                    reason_next = RS_DISABLED;
                end
            end
            ST_TILT_STARTED:
            begin
                mode_next   = ST_WAITING_TILT;
                reason_next = RS_INITIAL_REQUEST;
            end
            ST_IN_TILT:
            begin
                reason_next = RS_OTHER;
                if (!seated)
                begin
                    mode_next   = ST_STOPPED;
                    reason_next = RS_NOT_SEATED;
                end
                else
                begin
                    if (tick)
                    begin
                        second_count_next = sat_inc16(second_count_reg);
                    end
                    priority if (held_tilt)
                    begin
                        mode_next = (second_count_next >= tilt_min_seconds_reg) ?
                                    ST_DURATION_OK : ST_IN_TILT;
                    end
                    else if (item.angle_code == ANGLE_ENDED)
                    begin
                        mode_next   = ST_STOPPED;
                        reason_next = RS_END;
                    end
                    else
                    begin
                        mode_next = ST_IN_TILT;
                    end
                    if (!item.enabled)
                    begin
                        mode_next   = ST_STOPPED;
                        reason_next = RS_DISABLED;
                    end
                end
            end
            ST_DURATION_OK:
            begin
                if (!seated)
                begin
                    mode_next   = ST_STOPPED;
                    reason_next = RS_NOT_SEATED;
                end
                else
                begin
                    if (tick)
                    begin
                        second_count_next = sat_inc16(second_count_reg);
                    end
                    if (item.angle_code == ANGLE_ENDED)
                    begin
                        mode_next   = ST_STOPPED;
                        reason_next = RS_END_OK;
                    end
                    if (!item.enabled)
                    begin
                        mode_next   = ST_STOPPED;
                        reason_next = RS_DISABLED;
                    end
                end
            end
            ST_STOPPED:
            begin
                reason_next = RS_COMPLETE;
                mode_next   = ST_INIT;
            end
            default:
            begin
                mode_next   = ST_INIT;
                reason_next = RS_OTHER;
            end
        endcase
    end

    assign result.notify_state = mode_next;
    assign result.reason_code  = reason_next;

endmodule

>>> rtl/trf_out_stage.sv
// ----------------------------------------------------------------------------
// trf_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module trf_out_stage
    import trf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl_in,
    output logic       advance,
    input  out_item_t  result,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // advance when a result is waiting and the slot is free or draining
    assign advance = ctl_in.item_valid && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (advance)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/tilt_reminder_fsm.sv
// A request waits in the input register; the result register takes its result when
// free or draining. Throughput: one request per cycle while results are taken; the state
// update is one register step, so each item sees the state left by the one before it.
// Reset (rst_n low, asynchronous): state goes to init, reason to other, counters
// and last timestamp to zero, registers to 300 / 900 / 60 seconds.
// ----------------------------------------------------------------------------
// tilt_reminder_fsm: tilt reminder controller top level
// Input register, state machine core and result register in series.
// ----------------------------------------------------------------------------
module tilt_reminder_fsm
    import trf_pkg::*;
#(
    parameter int SNOOZE_PRESSES = SNOOZE_PRESSES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    trf_stream_if.sink   in_ch,
    trf_stream_if.source out_ch,
    trf_stream_if.sink   cfg_ch
);

    stage_ctl_t ctl;
    logic       advance;
    in_item_t   item;
    out_item_t  result;

    trf_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_data  (in_ch.data),
        .advance  (advance),
        .ctl      (ctl),
        .item     (item)
    );

    trf_core #(
        .SNOOZE_PRESSES (SNOOZE_PRESSES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_ch.valid),
        .cfg_ready (cfg_ch.ready),
        .cfg_data  (cfg_ch.data),
        .ctl       (ctl),
        .item      (item),
        .result    (result)
    );

    trf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl),
        .advance   (advance),
        .result    (result),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );

endmodule

>>> tb/reminder_checker.sv
// ----------------------------------------------------------------------------
// reminder_checker: prediction and compare for the tilt reminder controller
// Watches the request, result and register channels, keeps its own copy of
// the controller state and checks every result against the oldest prediction.
// ----------------------------------------------------------------------------
module reminder_checker
    import trf_pkg::*;
#(
    parameter int SNOOZE_PRESSES = SNOOZE_PRESSES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    trf_stream_if       in_mon,
    trf_stream_if       out_mon,
    trf_stream_if       cfg_mon,
    output int          fail_count,
    output int          pending,
    output int          n_requests,
    output int          n_results,
    output logic [15:0] states_seen
);

    state_t      mode;
    reason_t     reason;
    logic [15:0] second_cnt;
    logic [2:0]  press_cnt;
    logic [31:0] last_ts;
    logic [15:0] snooze_s;
    logic [15:0] interval_s;
    logic [15:0] min_s;
    out_item_t   owed_reports[$];
    out_item_t   oldest;

    assign pending = n_requests - n_results;

    task automatic count_second();
        if (second_cnt != 16'hFFFF)
            second_cnt = second_cnt + 16'd1;
    endtask

    task automatic advance_reminder(input in_item_t req);
        logic seated;
        logic tick;
        logic held;
        seated = (req.seating_code == SEAT_SEATED) || (req.seating_code == SEAT_CONFIRMING);
        tick   = (req.time_seconds != last_ts);
        held   = (req.angle_code == ANGLE_IN_TILT) || (req.angle_code == ANGLE_CONFIRMING);
        case (mode)
            ST_INIT:
            begin
                reason     = RS_OTHER;
                press_cnt  = '0;
                second_cnt = '0;
                if (req.seating_code == SEAT_SEATED)
                    mode = ST_WAIT;
                if (!req.enabled)
                    mode = ST_INIT;
            end
            ST_TRAVEL_ELAPSED:
                mode = req.moving ? ST_TRAVEL_ELAPSED : ST_WAITING_TILT;
            ST_WAIT:
            begin
                reason = RS_OTHER;
                if (req.moving)
                    mode = ST_TRAVEL;
                if (seated)
                begin
                    if (tick)
                    begin
                        count_second();
                        if (second_cnt >= interval_s || req.angle_code == ANGLE_IN_TILT)
                            mode = ST_TILT_STARTED;
                    end
                end
                else
                    mode = ST_INIT;
                if (!req.enabled)
                begin
                    mode   = ST_INIT;
                    reason = RS_DISABLED;
                end
            end
            ST_TRAVEL:
            begin
                reason = RS_OTHER;
                mode   = req.moving ? ST_TRAVEL : ST_WAIT;
                if (tick)
                    count_second();
                if (!seated)
                    mode = ST_INIT;
                if (!req.enabled)
                begin
                    mode   = ST_INIT;
                    reason = RS_DISABLED;
                end
            end
            ST_WAITING_TILT:
            begin
                reason     = RS_OTHER;
                second_cnt = '0;
                if (req.button_pressed)
                begin
                    if (press_cnt < PRESS_MAX)
                        press_cnt = press_cnt + 3'd1;
                    if (press_cnt >= SNOOZE_PRESSES)
                    begin
                        mode   = ST_SNOOZED;
                        reason = RS_SNOOZED;
                    end
                end
                else
                    press_cnt = '0;
                // travel and standing up win over tilt and disable
                if (req.moving)
                    mode = ST_TRAVEL_ELAPSED;
                else if (!seated)
                begin
                    mode   = ST_STOPPED;
                    reason = RS_NOT_SEATED;
                end
                else
                begin
                    if (req.angle_code == ANGLE_BEGUN || req.angle_code == ANGLE_IN_TILT)
                    begin
                        mode   = ST_IN_TILT;
                        reason = RS_TILT_BEGIN;
                    end
                    if (!req.enabled)
                    begin
                        mode   = ST_INIT;
                        reason = RS_DISABLED;
                    end
                end
            end
            ST_SNOOZED:
            begin
                reason = RS_OTHER;
                if (tick)
                begin
                    count_second();
                    if (second_cnt >= snooze_s || req.angle_code == ANGLE_IN_TILT)
                    begin
                        mode   = ST_WAITING_TILT;
                        reason = RS_TILT_REQUESTED;
                    end
                end
                if (!seated)
                begin
                    mode   = ST_STOPPED;
                    reason = RS_NOT_SEATED;
                end
                if (!req.enabled)
                begin
                    mode   = ST_INIT;
                    reason = RS_DISABLED;
                end
            end
            ST_TILT_STARTED:
            begin
                mode   = ST_WAITING_TILT;
                reason = RS_INITIAL_REQUEST;
            end
            ST_IN_TILT:
            begin
                reason = RS_OTHER;
                if (!seated)
                begin
                    mode   = ST_STOPPED;
                    reason = RS_NOT_SEATED;
                end
                else
                begin
                    if (tick)
                        count_second();
                    if (held)
                        mode = (second_cnt >= min_s) ? ST_DURATION_OK : ST_IN_TILT;
                    else if (req.angle_code == ANGLE_ENDED)
                    begin
                        mode   = ST_STOPPED;
                        reason = RS_END;
                    end
                    if (!req.enabled)
                    begin
                        mode   = ST_STOPPED;
                        reason = RS_DISABLED;
                    end
                end
            end
            ST_DURATION_OK:
            begin
                // reason is kept unless a new one is set
                if (!seated)
                begin
                    mode   = ST_STOPPED;
                    reason = RS_NOT_SEATED;
                end
                else
                begin
                    if (tick)
                        count_second();
                    if (req.angle_code == ANGLE_ENDED)
                    begin
                        mode   = ST_STOPPED;
                        reason = RS_END_OK;
                    end
                    if (!req.enabled)
                    begin
                        mode   = ST_STOPPED;
                        reason = RS_DISABLED;
                    end
                end
            end
            ST_STOPPED:
            begin
                reason = RS_COMPLETE;
                mode   = ST_INIT;
            end
            default:
            begin
                mode   = ST_INIT;
                reason = RS_OTHER;
            end
        endcase
        last_ts = req.time_seconds;
        owed_reports.push_back('{notify_state: mode, reason_code: reason});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode        = ST_INIT;
            reason      = RS_OTHER;
            second_cnt  = '0;
            press_cnt   = '0;
            last_ts     = '0;
            snooze_s    = SNOOZE_SECONDS_RST;
            interval_s  = TILT_INTERVAL_SECONDS_RST;
            min_s       = TILT_MIN_SECONDS_RST;
            owed_reports.delete();
            fail_count  <= 0;
            n_requests  <= 0;
            n_results   <= 0;
            states_seen <= '0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_index_t'(cfg_mon.data.index))
                    CFG_SNOOZE_SECONDS:        snooze_s   = cfg_mon.data.data;
                    CFG_TILT_INTERVAL_SECONDS: interval_s = cfg_mon.data.data;
                    CFG_TILT_MIN_SECONDS:      min_s      = cfg_mon.data.data;
                    default: ;
                endcase
            end
            // check the result before adding this edge's request
            if (out_mon.valid && out_mon.ready)
            begin
                n_results   <= n_results + 1;
                states_seen <= states_seen | (16'd1 << out_mon.data.notify_state);
                if (owed_reports.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result %0d arrived with nothing owed: state %0d reason %0d",
                                 n_results, out_mon.data.notify_state,
                                 out_mon.data.reason_code);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    oldest = owed_reports.pop_front();
                    if (out_mon.data.notify_state !== oldest.notify_state ||
                        out_mon.data.reason_code !== oldest.reason_code)
                    begin
                        if (fail_count < 10)
                            $display("result %0d: expected state %0d reason %0d, got state %0d reason %0d",
                                     n_results, oldest.notify_state, oldest.reason_code,
                                     out_mon.data.notify_state, out_mon.data.reason_code);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                advance_reminder(in_mon.data);
                n_requests <= n_requests + 1;
            end
        end
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the tilt reminder controller
// Drives short directed sequences, then seated sessions with random content
// and noise under several register settings, and a short seated trip. The
// checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb;
    import trf_pkg::*;

    localparam logic [1:0] SEAT_NONE    = 2'd0;
    localparam logic [1:0] SEAT_INVALID = 2'd3;
    localparam logic [2:0] ANGLE_NONE   = 3'd0;
    localparam logic [2:0] ANGLE_SPARE5 = 3'd5;
    localparam logic [2:0] ANGLE_SPARE6 = 3'd6;
    localparam logic [2:0] ANGLE_SPARE7 = 3'd7;
    localparam int         PHASE_ITEMS  = 160;
    localparam int         TRIP_SECONDS = 30;

    logic        clk;
    logic        rst_n;
    logic        no_idle;
    int          noise_pct;
    logic [31:0] now_ts;
    logic [15:0] cur_snooze;
    logic [15:0] cur_interval;
    logic [15:0] cur_min;
    int          n_sent;

    int          fail_count;
    int          pending;
    int          n_requests;
    int          n_results;
    logic [15:0] states_seen;

    trf_stream_if #(.payload_t(in_item_t))  in_if ();
    trf_stream_if #(.payload_t(out_item_t)) out_if ();
    trf_stream_if #(.payload_t(cfg_req_t))  cfg_if ();

    tilt_reminder_fsm dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    reminder_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_if),
        .out_mon     (out_if),
        .cfg_mon     (cfg_if),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_requests  (n_requests),
        .n_results   (n_results),
        .states_seen (states_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tilt_reminder_fsm test failed");
        $finish;
    end

    always @(posedge clk)
        out_if.ready <= no_idle || ($urandom_range(0, 99) >= 36);

    function automatic int bounded_len(input logic [15:0] v);
        return (v > 16'd20) ? 20 : int'(v);
    endfunction

    function automatic logic [1:0] any_seat();
        return ($urandom_range(0, 3) == 0) ? SEAT_CONFIRMING : SEAT_SEATED;
    endfunction

    // Hold valid across back-to-back requests; drop it only for a gap.
    task automatic send_item(input in_item_t req);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < 36)
            begin
                in_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_if.valid <= 1'b1;
        in_if.data  <= req;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic send_fields(input logic btn, input logic en, input logic [1:0] seat,
                               input logic [2:0] ang, input logic mv, input logic tick);
        in_item_t req;
        if (tick)
            now_ts = ($urandom_range(0, 99) < noise_pct) ? $urandom() : now_ts + 32'd1;
        req.time_seconds   = now_ts;
        req.button_pressed = btn;
        req.enabled        = en;
        req.seating_code   = seat;
        req.angle_code     = ang;
        req.moving         = mv;
        if ($urandom_range(0, 99) < noise_pct)
        begin
            case ($urandom_range(0, 4))
                0: req.enabled        = ~req.enabled;
                1: req.seating_code   = 2'($urandom_range(0, 3));
                2: req.angle_code     = 3'($urandom_range(0, 7));
                3: req.moving         = ~req.moving;
                default: req.button_pressed = ~req.button_pressed;
            endcase
        end
        send_item(req);
    endtask

    task automatic run_noise();
        in_item_t req;
        repeat ($urandom_range(5, 20))
        begin
            if ($urandom_range(0, 1))
                now_ts = ($urandom_range(0, 1)) ? $urandom() : now_ts + 32'd1;
            req.time_seconds   = now_ts;
            req.button_pressed = 1'($urandom_range(0, 1));
            req.enabled        = 1'($urandom_range(0, 1));
            req.seating_code   = 2'($urandom_range(0, 3));
            req.angle_code     = 3'($urandom_range(0, 7));
            req.moving         = 1'($urandom_range(0, 1));
            send_item(req);
        end
    endtask

    // Sit, wait out the interval, maybe snooze, tilt, then stand up.
    task automatic run_session();
        int n;
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        n = bounded_len(cur_interval) + $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            send_fields(1'b0, 1'b1, any_seat(),
                        ($urandom_range(0, 99) < 5) ? ANGLE_IN_TILT : ANGLE_NONE,
                        $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 85);
        repeat (2)
            send_fields(1'b0, 1'b1, any_seat(), ANGLE_NONE, 1'b0, 1'b1);
        if ($urandom_range(0, 1))
        begin
            repeat ($urandom_range(3, 6))
                send_fields(1'b1, 1'b1, any_seat(), ANGLE_NONE, 1'b0, 1'b1);
            n = bounded_len(cur_snooze) + 2;
            for (int i = 0; i < n; i++)
                send_fields(1'b0, 1'b1, any_seat(),
                            ($urandom_range(0, 99) < 5) ? ANGLE_IN_TILT : ANGLE_NONE,
                            1'b0, $urandom_range(0, 99) < 85);
            // one more press after the snooze wait snoozes again only if the press count is still high
            if ($urandom_range(0, 2) == 0)
            begin
                send_fields(1'b1, 1'b1, any_seat(), ANGLE_NONE, 1'b0, 1'b1);
                for (int i = 0; i < n; i++)
                    send_fields(1'b0, 1'b1, any_seat(), ANGLE_NONE, 1'b0, 1'b1);
            end
        end
        send_fields(1'b0, 1'b1, any_seat(), ANGLE_BEGUN, 1'b0, 1'b1);
        n = bounded_len(cur_min) + $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            send_fields(1'b0, 1'b1, any_seat(),
                        $urandom_range(0, 1) ? ANGLE_IN_TILT : ANGLE_CONFIRMING,
                        1'b0, $urandom_range(0, 99) < 85);
        case ($urandom_range(0, 3))
            0: send_fields(1'b0, 1'b1, SEAT_NONE, ANGLE_NONE, 1'b0, 1'b1);
            1: send_fields(1'b0, 1'b0, SEAT_SEATED, ANGLE_IN_TILT, 1'b0, 1'b1);
            default: send_fields(1'b0, 1'b1, any_seat(), ANGLE_ENDED, 1'b0, 1'b1);
        endcase
        repeat (2)
            send_fields(1'b0, 1'b1, SEAT_NONE, ANGLE_NONE, 1'b0, 1'b1);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Let the pipeline empty before touching registers.
    task automatic settle();
        drain();
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, data: val};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    initial
    begin
        int target;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        rst_n        <= 1'b0;
        no_idle      <= 1'b0;
        noise_pct    = 0;
        now_ts       = '0;
        n_sent       = 0;
        cur_snooze   = SNOOZE_SECONDS_RST;
        cur_interval = TILT_INTERVAL_SECONDS_RST;
        cur_min      = TILT_MIN_SECONDS_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first timestamp differs from zero and so is a new second, which init does not count
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_INVALID, ANGLE_SPARE5, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_SPARE6, 1'b0, 1'b0);
        send_fields(1'b0, 1'b1, SEAT_CONFIRMING, ANGLE_IN_TILT, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_SPARE7, 1'b0, 1'b0);
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b0);
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        // snooze press and travel on the same request
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b1, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b1, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        // press count is still high, so single presses snooze, also once it tops out
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_IN_TILT, 1'b0, 1'b1);
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_IN_TILT, 1'b0, 1'b1);
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_IN_TILT, 1'b0, 1'b1);
        send_fields(1'b1, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_IN_TILT, 1'b0, 1'b0);
        // wrap the timestamp through all ones to zero
        now_ts = 32'hFFFF_FFFE;
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_IN_TILT, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_BEGUN, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_CONFIRMING, 1'b0, 1'b1);
        send_fields(1'b0, 1'b0, SEAT_CONFIRMING, ANGLE_ENDED, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_NONE, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b0, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                1:
                begin
                    cur_snooze   = '0;
                    cur_interval = '0;
                    cur_min      = '0;
                end
                2:
                begin
                    cur_snooze   = 16'hFFFF;
                    cur_interval = 16'hFFFF;
                    cur_min      = 16'hFFFF;
                end
                3:
                begin
                    cur_snooze   = 16'd1;
                    cur_interval = 16'd2;
                    cur_min      = 16'd1;
                end
                default:
                begin
                    cur_snooze   = 16'($urandom_range(0, 8));
                    cur_interval = 16'($urandom_range(1, 12));
                    cur_min      = 16'($urandom_range(0, 8));
                end
            endcase
            write_reg(CFG_SNOOZE_SECONDS, cur_snooze);
            write_reg(CFG_TILT_INTERVAL_SECONDS, cur_interval);
            write_reg(CFG_TILT_MIN_SECONDS, cur_min);
            if (p == 1)
                write_reg(CFG_UNUSED, 16'($urandom()));
            cfg_if.valid <= 1'b0;
            no_idle      <= (p == 5);
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target)
            begin
                noise_pct = $urandom_range(0, 15);
                if ($urandom_range(0, 9) == 0)
                    run_noise();
                else
                    run_session();
                if ($urandom_range(0, 7) == 0)
                    drain();
            end
        end

        // short trip while seated with the longest interval
        settle();
        cur_interval = 16'hFFFF;
        write_reg(CFG_TILT_INTERVAL_SECONDS, cur_interval);
        cfg_if.valid <= 1'b0;
        no_idle      <= 1'b0;
        noise_pct    = 0;
        repeat (4)
            send_fields(1'b0, 1'b0, SEAT_NONE, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);
        send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b1, 1'b1);
        repeat (TRIP_SECONDS)
            send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b1, 1'b1);
        repeat (2)
            send_fields(1'b0, 1'b1, SEAT_SEATED, ANGLE_NONE, 1'b0, 1'b1);

        settle();
        $display("covered %0d requests and %0d checked results over seven register settings",
                 n_requests, n_results);
        $display("reached %0d of 10 states, including a seated trip under the longest interval",
                 $countones(states_seen));
        if (fail_count == 0 && pending == 0)
            $display("tilt_reminder_fsm test passed");
        else
            $display("tilt_reminder_fsm test failed");
        $finish;
    end

endmodule
